// ===== hdl/cmrq_pkg.sv =====
package cmrq_pkg;

  // Default accumulator width
  localparam int unsigned AccBitsDefault = 64;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgInZero  = 3'd0,
    CfgOutZero = 3'd1,
    CfgClampLo = 3'd2,
    CfgClampHi = 3'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StBias,
    StMulLo,
    StMulHi,
    StCombine,
    StShift,
    StFinish
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;
    logic add_bias;
    logic mul_lo;
    logic mul_hi;
    logic combine;
    logic shift;
    logic finish;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_tap;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/cmrq_ifs.sv =====
// Tap channel
interface cmrq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] activation;
  logic signed [7:0]  weight;
  logic               last_tap;
  logic signed [47:0] channel_bias;
  logic [30:0]        channel_multiplier;
  logic signed [5:0]  channel_shift;

  modport source (
    output valid, activation, weight, last_tap, channel_bias, channel_multiplier,
           channel_shift,
    input  ready
  );
  modport sink (
    input  valid, activation, weight, last_tap, channel_bias, channel_multiplier,
           channel_shift,
    output ready
  );
endinterface

// Result channel
interface cmrq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;

  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

// ===== hdl/cmrq_ctrl.sv =====
module cmrq_ctrl import cmrq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.last_tap) begin
            state_d = StBias;
          end
        end
      end
      StBias: begin
        cmd_o.add_bias = 1'b1;
        state_d        = StMulLo;
      end
      StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StCombine;
      end
      StCombine: begin
        cmd_o.combine = 1'b1;
        state_d       = StShift;
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        state_d     = StFinish;
      end
      StFinish: begin
        // Hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== hdl/cmrq_dp.sv =====
module cmrq_dp import cmrq_pkg::*; #(
  parameter int unsigned ACC_BITS = AccBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [15:0]  activation_i,
  input  logic signed [7:0]   weight_i,
  input  logic                last_tap_i,
  input  logic signed [47:0]  channel_bias_i,
  input  logic [30:0]         channel_multiplier_i,
  input  logic signed [5:0]   channel_shift_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [15:0]  result_o
);

  // Configuration registers
  logic signed [15:0] izo_q, ozo_q, clo_q, chi_q;

  // Accumulator and last-tap operands
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [47:0]         bias_q;
  logic [14:0]                m15_q, m15_d;
  logic signed [6:0]          t_q, t_d;

  // Requantization pipeline registers
  logic [46:0]        plo_q;
  logic [31:0]        phi_q;
  logic [63:0]        p_q;
  logic signed [31:0] q_q;
  logic signed [15:0] result_q, result_d;
  logic               out_valid_q;

  logic signed [16:0] act_off;
  logic signed [24:0] prod;
  logic signed [63:0] acc64;
  logic [46:0]        lo_full, hi_full;
  logic [31:0]        mult_sum;
  logic [5:0]         t_m1;
  logic [63:0]        rnd;
  logic [6:0]         t_neg;
  logic [63:0]        q64;
  logic signed [32:0] v;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      izo_q <= 16'sd0;
      ozo_q <= 16'sd0;
      clo_q <= -16'sd32768;
      chi_q <= 16'sd32767;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInZero:  izo_q <= cfg_wdata_i;
        CfgOutZero: ozo_q <= cfg_wdata_i;
        CfgClampLo: clo_q <= cfg_wdata_i;
        CfgClampHi: chi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Tap product
  assign act_off = 17'(activation_i) + 17'(izo_q);
  assign prod    = 25'(act_off) * 25'(weight_i);
  assign acc64   = 64'(acc_q);

  // Accumulator: add taps, add bias, clear after its last read
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.take) begin
      acc_d = acc_q + ACC_BITS'(prod);
    end else if (cmd_i.add_bias) begin
      acc_d = acc_q + ACC_BITS'(bias_q);
    end else if (cmd_i.mul_hi) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Round the Q31 multiplier to 15 bits, turn the exponent into a right shift
  assign mult_sum = 32'(channel_multiplier_i) + 32'h0000_8000;
  assign m15_d    = (channel_multiplier_i < 31'h7FFF_0000) ? mult_sum[30:16] : 15'h7FFF;
  assign t_d      = 7'sd15 - 7'(channel_shift_i);

  // Partial products of the 64x15 multiply, low half then high half
  assign lo_full = 47'(acc64[31:0]) * 47'(m15_q);
  assign hi_full = 47'(acc64[63:32]) * 47'(m15_q);

  // Rounding term for right shifts
  assign t_m1 = 6'(t_q - 7'sd1);
  assign rnd  = (t_q > 7'sd0) ? (64'd1 << t_m1) : 64'd0;

  // Arithmetic right shift, or plain left shift for large exponents
  assign t_neg = 7'(-t_q);
  assign q64   = (t_q > 7'sd0) ? 64'($signed(p_q) >>> t_q[5:0]) : (p_q << t_neg[4:0]);

  // Output offset and clamp
  assign v = 33'(q_q) + 33'(ozo_q);
  always_comb begin
    if (v < 33'(clo_q)) begin
      result_d = clo_q;
    end else if (v > 33'(chi_q)) begin
      result_d = chi_q;
    end else begin
      result_d = v[15:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      bias_q <= channel_bias_i;
      m15_q  <= m15_d;
      t_q    <= t_d;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= lo_full;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= hi_full[31:0];
    end
    if (cmd_i.combine) begin
      p_q <= 64'(plo_q) + {phi_q, 32'h0} + rnd;
    end
    if (cmd_i.shift) begin
      q_q <= q64[31:0];
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  // Output register valid: load on finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.finish | (out_valid_q & ~out_ready_i);
    end
  end

  assign sts_o.last_tap = last_tap_i;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign result_o       = result_q;

endmodule

// ===== hdl/conv_mac_requant_s16_acc64_top.sv =====
// Channel   Dir  Payload
// in_i      in   activation, weight, last_tap, channel_bias, channel_multiplier,
//                channel_shift
// out_o     out  result
// cfg_*     in   register index, 16-bit write data
//
// A tap that is not last is taken in the idle state; taps can follow back to back.
// A last tap then steps through bias add, two partial products of the
// 64x15 requantization multiply, round, shift, and offset and clamp.
// The last step waits while the output register still holds an untaken
// result; the input side is ready only in the idle state.
// Reset clears the accumulator and the output valid and restores the default
// configuration (zero offsets, full int16 clamp range).
module conv_mac_requant_s16_acc64_top import cmrq_pkg::*; #(
  parameter int unsigned ACC_BITS = AccBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  cmrq_in_if.sink             in_i,
  cmrq_out_if.source          out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  cmrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Accumulate and requantize
  cmrq_dp #(
    .ACC_BITS (ACC_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .activation_i         (in_i.activation),
    .weight_i             (in_i.weight),
    .last_tap_i           (in_i.last_tap),
    .channel_bias_i       (in_i.channel_bias),
    .channel_multiplier_i (in_i.channel_multiplier),
    .channel_shift_i      (in_i.channel_shift),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_ready_i          (out_o.ready),
    .out_valid_o          (out_o.valid),
    .result_o             (out_o.result)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top import cmrq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AccBits    = AccBitsDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCyc  = 12;

  // One tap as the sender sees it
  typedef struct {
    logic signed [15:0] act;
    logic signed [7:0]  wt;
    logic               last;
    logic signed [47:0] bias;
    logic [30:0]        mult;
    logic signed [5:0]  shift;
  } tap_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  cmrq_in_if  tap_ch ();
  cmrq_out_if res_ch ();

  conv_mac_requant_s16_acc64_top #(
    .ACC_BITS(AccBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (tap_ch),
    .out_o      (res_ch)
  );

  // Predictor state: configuration copy and the running channel sum
  logic signed [15:0] in_zero_q  = 16'sd0;
  logic signed [15:0] out_zero_q = 16'sd0;
  logic signed [15:0] clamp_lo_q = -16'sd32768;
  logic signed [15:0] clamp_hi_q = 16'sd32767;
  longint             mac_acc    = 0;
  logic signed [15:0] expected_results[$];

  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // Clock: 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Wrap a sum to the accumulator width
  function automatic longint wrap_acc(input longint x);
    return (x <<< (64 - AccBits)) >>> (64 - AccBits);
  endfunction

  // Rounded Q15 multiply and power-of-two scaling of the channel sum
  function automatic longint requantize(input logic [63:0] acc, input logic [30:0] mult,
                                        input logic signed [5:0] shift);
    logic [63:0] m15;
    logic [63:0] prod;
    logic [63:0] q;
    int          t;
    m15  = (mult < 31'h7FFF0000) ? ((64'(mult) + 64'd32768) >> 16) : 64'h7FFF;
    t    = 15 - int'(shift);
    prod = acc * m15;
    if (t >= 1) begin
      prod = prod + (64'd1 << (t - 1));
      q    = 64'($signed(prod) >>> t);
    end else begin
      q = prod << (-t);
    end
    return longint'($signed(q[31:0]));
  endfunction

  // Fold one accepted tap into the channel sum; close the channel on the last tap
  function automatic void predict_tap(input tap_t tp);
    longint a;
    longint w;
    longint v;
    a       = longint'(tp.act) + longint'(in_zero_q);
    w       = longint'(tp.wt);
    mac_acc = wrap_acc(mac_acc + a * w);
    if (!tp.last) return;
    mac_acc = wrap_acc(mac_acc + longint'(tp.bias));
    v = requantize(mac_acc, tp.mult, tp.shift) + longint'(out_zero_q);
    if (v < longint'(clamp_lo_q)) begin
      v = longint'(clamp_lo_q);
    end else if (v > longint'(clamp_hi_q)) begin
      v = longint'(clamp_hi_q);
    end
    expected_results.push_back(16'(v));
    mac_acc = 0;
  endfunction

  // Compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    logic signed [15:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", res_ch.result));
      end else begin
        want = expected_results.pop_front();
        if (res_ch.result !== want) begin
          report_mismatch($sformatf("result %0d, expected %0d", res_ch.result, want));
        end
      end
    end
  end

  // Send one tap, with random idle cycles ahead of it
  task automatic send_tap(input tap_t tp);
    while ($urandom_range(99) < tx_idle_pct) begin
      tap_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tap_ch.valid              <= 1'b1;
    tap_ch.activation         <= tp.act;
    tap_ch.weight             <= tp.wt;
    tap_ch.last_tap           <= tp.last;
    tap_ch.channel_bias       <= tp.bias;
    tap_ch.channel_multiplier <= tp.mult;
    tap_ch.channel_shift      <= tp.shift;
    do @(posedge clk_i); while (!tap_ch.ready);
    predict_tap(tp);
  endtask

  // Hold the input side until all results are back and the block has settled
  task automatic quiesce();
    tap_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic signed [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgInZero:  in_zero_q  = val;
      CfgOutZero: out_zero_q = val;
      CfgClampLo: clamp_lo_q = val;
      CfgClampHi: clamp_hi_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic signed [15:0] in_zero,
                              input logic signed [15:0] out_zero,
                              input logic signed [15:0] lo, input logic signed [15:0] hi);
    quiesce();
    write_reg(CfgInZero, in_zero);
    write_reg(CfgOutZero, out_zero);
    write_reg(CfgClampLo, lo);
    write_reg(CfgClampHi, hi);
    cfg_we_i <= 1'b0;
  endtask

  function automatic tap_t mk_tap(input logic signed [15:0] act, input logic signed [7:0] wt,
                                  input logic last, input logic signed [47:0] bias,
                                  input logic [30:0] mult, input logic signed [5:0] shift);
    tap_t tp;
    tp.act   = act;
    tp.wt    = wt;
    tp.last  = last;
    tp.bias  = bias;
    tp.mult  = mult;
    tp.shift = shift;
    return tp;
  endfunction

  // Random tap with weight on field extremes and on useful scaling ranges
  function automatic tap_t random_tap(input logic last);
    tap_t tp;
    case ($urandom_range(7))
      0:       tp.act = -16'sd32768;
      1:       tp.act = 16'sd32767;
      default: tp.act = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0:       tp.wt = -8'sd128;
      1:       tp.wt = 8'sd127;
      default: tp.wt = 8'($urandom);
    endcase
    tp.last = last;
    case ($urandom_range(4))
      0:       tp.bias = 48'(longint'($urandom_range(2000000)) - 1000000);
      1:       tp.bias = 48'({$urandom, $urandom});
      2:       tp.bias = $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      3:       tp.bias = 48'sd0;
      default: tp.bias = 48'(longint'($urandom_range(200000)) - 100000);
    endcase
    case ($urandom_range(4))
      0: tp.mult = {1'b1, 30'($urandom)};
      1: begin
        case ($urandom_range(3))
          0:       tp.mult = 31'h0;
          1:       tp.mult = 31'h7FFEFFFF;
          2:       tp.mult = 31'h7FFF0000;
          default: tp.mult = 31'h7FFFFFFF;
        endcase
      end
      default: tp.mult = 31'($urandom);
    endcase
    case ($urandom_range(4))
      0:       tp.shift = 6'(int'($urandom_range(62)) - 31);
      1:       tp.shift = 6'(int'($urandom_range(6)) + 12);
      default: tp.shift = 6'(int'($urandom_range(18)) - 22);
    endcase
    return tp;
  endfunction

  function automatic logic signed [15:0] random_cfg_val(input bit narrow);
    case ($urandom_range(5))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return narrow ? 16'(int'($urandom_range(1000)) - 500) : 16'($urandom);
    endcase
  endfunction

  // Rounding, saturation of the multiplier and both shift directions, reset config
  task automatic test_requant_corners();
    send_tap(mk_tap(16'sd32767, 8'sd127, 1'b1, 48'sd0, 31'h7FFFFFFF, 6'sd0));
    send_tap(mk_tap(-16'sd32768, -8'sd128, 1'b0, 48'sd0, 31'h0, 6'sd0));
    send_tap(mk_tap(-16'sd32768, 8'sd127, 1'b0, 48'sd0, 31'h0, 6'sd0));
    send_tap(mk_tap(16'sd32767, -8'sd128, 1'b1, 48'sh7FFF_FFFF_FFFF, 31'h7FFF0000, 6'sd31));
    send_tap(mk_tap(16'sd1234, -8'sd77, 1'b1, 48'sh8000_0000_0000, 31'h7FFEFFFF, -6'sd31));
    send_tap(mk_tap(16'sd3, 8'sd5, 1'b1, 48'sd12345, 31'h40000000, 6'sd15));
    send_tap(mk_tap(16'sd3, 8'sd5, 1'b1, 48'sd12345, 31'h40000000, 6'sd14));
    send_tap(mk_tap(-16'sd3, 8'sd5, 1'b1, -48'sd12345, 31'h40000000, 6'sd16));
    send_tap(mk_tap(16'sd100, 8'sd100, 1'b1, 48'sd777, 31'h0, -6'sd10));
    send_tap(mk_tap(16'sd1, 8'sd1, 1'b1, -48'sd1, 31'h40000000, -6'sd16));
    send_tap(mk_tap(16'sd1, 8'sd1, 1'b1, 48'sd0, 31'h40000000, -6'sd15));
  endtask

  // Offsets at their limits and inverted, then narrow, clamp limits
  task automatic test_config_extremes();
    apply_config(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_tap(mk_tap(16'sd500, 8'sd3, 1'b0, 48'sd0, 31'h0, 6'sd0));
    send_tap(mk_tap(-16'sd32768, 8'sd127, 1'b1, 48'sd0, 31'h7FFFFFFF, -6'sd20));
    send_tap(mk_tap(16'sd0, 8'sd0, 1'b1, 48'sd0, 31'h0, 6'sd0));
    apply_config(16'sd32767, -16'sd32768, -16'sd100, 16'sd100);
    send_tap(mk_tap(16'sd32767, -8'sd128, 1'b0, 48'sd0, 31'h0, 6'sd0));
    send_tap(mk_tap(16'sd10, 8'sd2, 1'b1, 48'sd5000, 31'h60000000, -6'sd5));
    send_tap(mk_tap(16'sd0, 8'sd1, 1'b1, 48'sh7FFF_FFFF_0000, 31'h7FFFFFFF, 6'sd0));
  endtask

  // Well-formed channels of random length under one idle pattern
  task automatic test_random_channels(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned n_taps, input bit hold_midway);
    int unsigned sent;
    int unsigned len;
    bit          held;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = random_cfg_val(1'b1);
    hi = random_cfg_val(1'b1);
    if (lo > hi && $urandom_range(3) != 0) begin
      {lo, hi} = {hi, lo};
    end
    apply_config(random_cfg_val($urandom_range(3) != 0), random_cfg_val(1'b1), lo, hi);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    held = 1'b0;
    while (sent < n_taps) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_tap(random_tap(i == len - 1));
      end
      sent += len;
      // Starve the block once until everything has drained
      if (hold_midway && !held && sent >= n_taps / 2) begin
        quiesce();
        held = 1'b1;
      end
    end
    tx_idle_pct = 0;
    rx_idle_pct = 0;
  endtask

  initial begin
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = CfgInZero;
    cfg_wdata_i               = '0;
    tap_ch.valid              = 1'b0;
    tap_ch.activation         = '0;
    tap_ch.weight             = '0;
    tap_ch.last_tap           = 1'b0;
    tap_ch.channel_bias       = '0;
    tap_ch.channel_multiplier = '0;
    tap_ch.channel_shift      = '0;
    res_ch.ready              = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_requant_corners();
    test_config_extremes();
    test_random_channels(34, 61, 600, 1'b1);
    test_random_channels(61, 34, 600, 1'b0);
    test_random_channels(0, 0, 600, 1'b1);

    quiesce();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
